// ----- rtl/core/qpht_pkg.sv -----
// Shared types and constants of the quadratic probe hash table.
package qpht_pkg;

  localparam logic [63:0] MixMulA  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixMulB  = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] HashFree = 64'h0;
  localparam logic [63:0] HashGone = 64'hffffffffffffffff;
  localparam logic [10:0] CountMax = 11'h7ff;
  localparam logic [10:0] SlotsRst = 11'd1021;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_PROBE,
    S_ACT
  } state_e;

  typedef struct packed {
    logic hash;
    logic key;
    logic value;
  } store_we_t;

endpackage

// ----- rtl/core/qpht_mix.sv -----
// Murmur3 64-bit finalizer built on one shared 32x32 multiplier.
module qpht_mix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [63:0] hash_o
);

  logic [63:0] a_q, a_d, acc_q, acc_d, kk, pp, fin, hash_q, hash_d;
  logic [31:0] m_a, m_b;
  logic [1:0]  s_q, s_d;
  logic        phase_q, phase_d, busy_q, busy_d, done_q, done_d;

  assign kk  = phase_q ? qpht_pkg::MixMulB : qpht_pkg::MixMulA;
  assign pp  = 64'(m_a) * 64'(m_b);
  assign fin = acc_q ^ (acc_q >> 33);

  always_comb begin
    m_a     = a_q[31:0];
    m_b     = kk[31:0];
    a_d     = a_q;
    acc_d   = acc_q;
    s_d     = s_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    hash_d  = hash_q;
    if (start_i) begin
      a_d     = key_i ^ (key_i >> 33);
      s_d     = 2'd0;
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      case (s_q)
        2'd0: begin
          acc_d = pp;
          s_d   = 2'd1;
        end
        2'd1: begin
          m_b   = kk[63:32];
          acc_d = acc_q + {pp[31:0], 32'h0};
          s_d   = 2'd2;
        end
        2'd2: begin
          m_a   = a_q[63:32];
          acc_d = acc_q + {pp[31:0], 32'h0};
          s_d   = 2'd3;
        end
        default: begin
          s_d = 2'd0;
          if (!phase_q) begin
            a_d     = fin;
            phase_d = 1'b1;
          end else begin
            busy_d = 1'b0;
            done_d = 1'b1;
            if (fin == qpht_pkg::HashFree) hash_d = 64'd1;
            else if (fin == qpht_pkg::HashGone) hash_d = qpht_pkg::HashGone - 64'd1;
            else hash_d = fin;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    acc_q   <= acc_d;
    s_q     <= s_d;
    phase_q <= phase_d;
    hash_q  <= hash_d;
  end

  assign done_o = done_q;
  assign hash_o = hash_q;

endmodule

// ----- rtl/core/qpht_mod.sv -----
// Remainder of a 64-bit hash by the slot count, four bits per cycle.
module qpht_mod #(
  parameter int unsigned AW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   dividend_i,
  input  logic [AW-1:0] divisor_i,
  output logic          done_o,
  output logic [AW-1:0] rem_o
);

  logic [63:0]   dvd_q, dvd_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [AW:0]   r;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    r      = '0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int i = 0; i < 4; i++) begin
        r     = {rem_d, dvd_d[63]};
        dvd_d = dvd_d << 1;
        if (r >= {1'b0, divisor_i}) r = r - {1'b0, divisor_i};
        rem_d = r[AW-1:0];
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/core/qpht_store.sv -----
// Slot memories: hash, key and value, one shared address, registered reads.
module qpht_store #(
  parameter int unsigned IW = 10
) (
  input  logic                clk_i,
  input  logic [IW-1:0]       addr_i,
  input  qpht_pkg::store_we_t we_i,
  input  logic [63:0]         hash_i,
  input  logic [63:0]         key_i,
  input  logic [31:0]         value_i,
  output logic [63:0]         hash_o,
  output logic [63:0]         key_o,
  output logic [31:0]         value_o
);

  logic [63:0] hash_mem  [2**IW];
  logic [63:0] key_mem   [2**IW];
  logic [31:0] value_mem [2**IW];

  always_ff @(posedge clk_i) begin
    if (we_i.hash) hash_mem[addr_i] <= hash_i;
    hash_o <= hash_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.key) key_mem[addr_i] <= key_i;
    key_o <= key_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.value) value_mem[addr_i] <= value_i;
    value_o <= value_mem[addr_i];
  end

endmodule

// ----- rtl/core/quadratic_probe_hash_table.sv -----
// Top level of the quadratic probe hash table with 64-bit integer keys.
//
// Slave channel s_axis_*: one command per transfer, kind in tuser, key and
// value in tdata. Master channel m_axis_*: one result per command, status
// in tuser, stored value, slot index and occupied count in tdata.
// cfg_we_i/cfg_wdata_i write the slot count used as probing modulus; write
// it only while no command is in flight.
// Steps per command: accept, the Murmur3 finalizer on the shared 32x32
// multiplier, the remainder by the slot count (four quotient bits a cycle),
// the read of the home slot, then the probes on the slot memories, and
// last the update of the table and the registered result.
// A command walks at most as many probes as the slot count; unused
// command code 3 skips the walk.
// One command is worked on at a time. After reset the block sweeps the
// hash memory to free, one slot a cycle, with tready low.
// A held result does not block acceptance of the next command; that
// command waits at its final update until the result register is free.
module quadratic_probe_hash_table #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [10:0]  cfg_wdata_i,     // slots_in_use
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,    // key[63:0], value[95:64]
  input  logic [1:0]   s_axis_tuser,    // command[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,    // stored_value[31:0], slot_index[41:32],
                                        // occupied_count[52:42], zero[55:53]
  output logic [1:0]   m_axis_tuser     // status[1:0]
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AW = IW + 1;

  qpht_pkg::state_e state_q, state_d;

  logic [10:0]   slots_q, cnt_q, cnt_d;
  logic [AW-1:0] n;
  logic [1:0]    cmd_q;
  logic [63:0]   key_q, hash_q;
  logic [31:0]   val_q, hitval_q, hitval_d;
  logic [IW-1:0] cur_q, cur_d, hit_q, hit_d, gone_q, gone_d, free_q, free_d;
  logic [AW-1:0] sq_q, sq_d, odd_q, odd_d, p_q, p_d, clr_q, clr_d;
  logic          found_q, found_d, hgone_q, hgone_d, hfree_q, hfree_d;

  // result register
  logic          ovalid_q;
  logic [1:0]    ostat_q;
  logic [31:0]   oval_q;
  logic [IW-1:0] oidx_q;
  logic [10:0]   ocnt_q;
  logic          resp_load;
  logic [1:0]    rstat;
  logic [31:0]   rval;
  logic [IW-1:0] ridx;

  logic          accept;
  logic          mix_done, mod_done;
  logic [63:0]   mix_hash;
  logic [AW-1:0] mod_rem;

  logic [IW-1:0]       mem_addr;
  qpht_pkg::store_we_t mem_we;
  logic [63:0]         mem_hash_wr, rd_hash, rd_key;
  logic [31:0]         rd_val;

  logic          is_gone, is_free, is_hit, take_gone, stop, last;
  logic [AW:0]   t_idx, t_sq, t_odd;
  logic [IW-1:0] nxt_idx;
  logic [IW-1:0] tgt;

  // Clamp the register to 1..SLOTS.
  always_comb begin
    if (slots_q == 11'd0) n = AW'(1);
    else if (32'(slots_q) > SLOTS) n = AW'(SLOTS);
    else n = AW'(slots_q);
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == qpht_pkg::S_IDLE);

  qpht_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && (s_axis_tuser != qpht_pkg::CMD_UNUSED)),
    .key_i  (s_axis_tdata[63:0]),
    .done_o (mix_done),
    .hash_o (mix_hash)
  );

  qpht_mod #(.AW(AW)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mix_done),
    .dividend_i(mix_hash),
    .divisor_i (n),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  qpht_store #(.IW(IW)) u_store (
    .clk_i  (clk_i),
    .addr_i (mem_addr),
    .we_i   (mem_we),
    .hash_i (mem_hash_wr),
    .key_i  (key_q),
    .value_i(val_q),
    .hash_o (rd_hash),
    .key_o  (rd_key),
    .value_o(rd_val)
  );

  // Evaluate the slot read last cycle at cur_q.
  assign is_gone   = (rd_hash == qpht_pkg::HashGone);
  assign is_free   = (rd_hash == qpht_pkg::HashFree);
  assign is_hit    = (rd_hash == hash_q) && (rd_key == key_q);
  assign take_gone = !hgone_q && is_gone;
  assign stop      = !take_gone && (is_free || is_hit);
  assign last      = ((p_q + AW'(1)) == n);

  // Next probe address and the running square and odd step, all mod n.
  always_comb begin
    t_idx = {1'b0, AW'(cur_q)} + {1'b0, sq_q};
    if (t_idx >= {1'b0, n}) t_idx = t_idx - {1'b0, n};
    nxt_idx = t_idx[IW-1:0];
    t_sq = {1'b0, sq_q} + {1'b0, odd_q};
    if (t_sq >= {1'b0, n}) t_sq = t_sq - {1'b0, n};
    t_odd = {1'b0, odd_q} + (AW+1)'(2);
    if (t_odd >= {1'b0, n}) t_odd = t_odd - {1'b0, n};
    if (t_odd >= {1'b0, n}) t_odd = t_odd - {1'b0, n};
  end

  assign tgt = hgone_q ? gone_q : free_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    sq_d        = sq_q;
    odd_d       = odd_q;
    p_d         = p_q;
    clr_d       = clr_q;
    hit_d       = hit_q;
    gone_d      = gone_q;
    free_d      = free_q;
    hitval_d    = hitval_q;
    found_d     = found_q;
    hgone_d     = hgone_q;
    hfree_d     = hfree_q;
    mem_addr    = cur_q;
    mem_we      = '0;
    mem_hash_wr = hash_q;
    resp_load   = 1'b0;
    rstat       = qpht_pkg::ST_MISS;
    rval        = '0;
    ridx        = '0;
    case (state_q)
      qpht_pkg::S_CLEAR: begin
        // Sweep every slot to free.
        mem_addr    = clr_q[IW-1:0];
        mem_we.hash = 1'b1;
        mem_hash_wr = qpht_pkg::HashFree;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(SLOTS - 1)) state_d = qpht_pkg::S_IDLE;
      end
      qpht_pkg::S_IDLE: begin
        if (accept) begin
          found_d = 1'b0;
          hgone_d = 1'b0;
          hfree_d = 1'b0;
          state_d = (s_axis_tuser == qpht_pkg::CMD_UNUSED) ? qpht_pkg::S_ACT
                                                            : qpht_pkg::S_HASH;
        end
      end
      qpht_pkg::S_HASH: begin
        if (mix_done) state_d = qpht_pkg::S_MOD;
      end
      qpht_pkg::S_MOD: begin
        // Issue the read of the home slot as the remainder lands.
        if (mod_done) begin
          mem_addr = mod_rem[IW-1:0];
          cur_d    = mod_rem[IW-1:0];
          p_d      = '0;
          sq_d     = (n == AW'(1)) ? AW'(0) : AW'(1);
          if (n == AW'(1) || n == AW'(3)) odd_d = AW'(0);
          else if (n == AW'(2)) odd_d = AW'(1);
          else odd_d = AW'(3);
          state_d  = qpht_pkg::S_PROBE;
        end
      end
      qpht_pkg::S_PROBE: begin
        // One probe a cycle: the next read goes out while this one is judged.
        mem_addr = nxt_idx;
        if (take_gone) begin
          hgone_d = 1'b1;
          gone_d  = cur_q;
        end
        if (stop) begin
          if (is_free) begin
            hfree_d = 1'b1;
            free_d  = cur_q;
          end else begin
            found_d  = 1'b1;
            hit_d    = cur_q;
            hitval_d = rd_val;
          end
        end
        if (stop || last) begin
          state_d = qpht_pkg::S_ACT;
        end else begin
          cur_d = nxt_idx;
          sq_d  = t_sq[AW-1:0];
          odd_d = t_odd[AW-1:0];
          p_d   = p_q + AW'(1);
        end
      end
      qpht_pkg::S_ACT: begin
        // Hold until the result register is free, then update and respond.
        if (!ovalid_q || m_axis_tready) begin
          resp_load = 1'b1;
          state_d   = qpht_pkg::S_IDLE;
          case (cmd_q)
            qpht_pkg::CMD_LOOKUP: begin
              if (found_q) begin
                rstat = qpht_pkg::ST_OK;
                rval  = hitval_q;
                ridx  = hit_q;
              end
            end
            qpht_pkg::CMD_INSERT: begin
              if (found_q) begin
                mem_addr     = hit_q;
                mem_we.value = 1'b1;
                rstat        = qpht_pkg::ST_OK;
                ridx         = hit_q;
              end else if (hgone_q || hfree_q) begin
                mem_addr = tgt;
                mem_we   = '{hash: 1'b1, key: 1'b1, value: 1'b1};
                if (cnt_q != qpht_pkg::CountMax) cnt_d = cnt_q + 11'd1;
                rstat = qpht_pkg::ST_OK;
                ridx  = tgt;
              end else begin
                rstat = qpht_pkg::ST_FULL;
              end
            end
            qpht_pkg::CMD_REMOVE: begin
              if (found_q) begin
                mem_addr    = hit_q;
                mem_we.hash = 1'b1;
                mem_hash_wr = qpht_pkg::HashGone;
                if (cnt_q != 11'd0) cnt_d = cnt_q - 11'd1;
                rstat = qpht_pkg::ST_OK;
                ridx  = hit_q;
              end
            end
            default: begin
              rstat = qpht_pkg::ST_MISS;
            end
          endcase
        end
      end
      default: state_d = qpht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= qpht_pkg::S_CLEAR;
      slots_q  <= qpht_pkg::SlotsRst;
      cnt_q    <= '0;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
      found_q  <= 1'b0;
      hgone_q  <= 1'b0;
      hfree_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      found_q <= found_d;
      hgone_q <= hgone_d;
      hfree_q <= hfree_d;
      if (cfg_we_i) slots_q <= cfg_wdata_i;
      if (resp_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    sq_q     <= sq_d;
    odd_q    <= odd_d;
    p_q      <= p_d;
    hit_q    <= hit_d;
    gone_q   <= gone_d;
    free_q   <= free_d;
    hitval_q <= hitval_d;
    if (accept) begin
      cmd_q <= s_axis_tuser;
      key_q <= s_axis_tdata[63:0];
      val_q <= s_axis_tdata[95:64];
    end
    if (mix_done) hash_q <= mix_hash;
    if (resp_load) begin
      ostat_q <= rstat;
      oval_q  <= rval;
      oidx_q  <= ridx;
      ocnt_q  <= cnt_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {3'b000, ocnt_q, 10'(oidx_q), oval_q};

  // The walk never addresses a slot outside the modulus.
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == qpht_pkg::S_PROBE |-> AW'(cur_q) < n)
    else $error("probe index beyond slot count");

  // Only an insert can report a full table.
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_load && cmd_q != qpht_pkg::CMD_INSERT |=> ostat_q != qpht_pkg::ST_FULL)
    else $error("full status on a non-insert command");

  // A successful remove lowers the occupied count by one.
  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_load && cmd_q == qpht_pkg::CMD_REMOVE && found_q && cnt_q != 11'd0
    |=> cnt_q == $past(cnt_q) - 11'd1)
    else $error("remove did not lower the occupied count");

  // No command is taken during the clearing sweep.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == qpht_pkg::S_CLEAR |-> !s_axis_tready)
    else $error("command accepted while clearing");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of the quadratic probe hash table.
module testbench;
  import qpht_pkg::*;

  localparam int unsigned NumSlots = 1024;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    status_e     status;
    logic [31:0] stored_value;
    logic [9:0]  slot_index;
    logic [10:0] occupied_count;
  } table_result_t;

  // Predicts each result from a private copy of the table and checks the DUT.
  class table_scoreboard;
    logic [63:0] hash_mem[NumSlots];
    logic [63:0] key_mem[NumSlots];
    logic [31:0] value_mem[NumSlots];
    logic [10:0] occupied;
    logic [10:0] slots_cfg;
    table_result_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits;
    int unsigned misses;
    int unsigned fulls;

    function new();
      foreach (hash_mem[i]) begin
        hash_mem[i] = HashFree;
        key_mem[i] = '0;
        value_mem[i] = '0;
      end
      occupied = '0;
      slots_cfg = SlotsRst;
      errors = 0;
      checked = 0;
      hits = 0;
      misses = 0;
      fulls = 0;
    endfunction

    function logic [63:0] murmur_mix(logic [63:0] k);
      logic [63:0] h;
      h = k ^ (k >> 33);
      h = h * MixMulA;
      h = h ^ (h >> 33);
      h = h * MixMulB;
      h = h ^ (h >> 33);
      if (h == HashFree) h = 64'd1;
      else if (h == HashGone) h = HashGone - 64'd1;
      return h;
    endfunction

    // Walk the probe sequence and update the table as the block would.
    function void note_command(logic [1:0] cmd, logic [63:0] k, logic [31:0] val);
      table_result_t r;
      int unsigned n;
      int unsigned idx;
      int unsigned stp;
      int unsigned hit_at;
      int unsigned free_at;
      int unsigned gone_at;
      int unsigned t;
      bit found;
      bit have_free;
      bit have_gone;
      logic [63:0] h;
      r.status = ST_MISS;
      r.stored_value = '0;
      r.slot_index = '0;
      if (cmd != CmdUnused) begin
        n = 32'(slots_cfg);
        if (n == 0) n = 1;
        if (n > NumSlots) n = NumSlots;
        h = murmur_mix(k);
        idx = 32'(h % 64'(n));
        stp = 1;
        found = 0;
        have_free = 0;
        have_gone = 0;
        hit_at = 0;
        free_at = 0;
        gone_at = 0;
        for (int unsigned p = 0; p < n; p++) begin
          if (!have_gone && hash_mem[idx] == HashGone) begin
            have_gone = 1;
            gone_at = idx;
          end else if (hash_mem[idx] == HashFree) begin
            have_free = 1;
            free_at = idx;
            break;
          end else if (hash_mem[idx] == h && key_mem[idx] == k) begin
            found = 1;
            hit_at = idx;
            break;
          end
          idx = 32'((64'(idx) + 64'(stp) * 64'(stp)) % 64'(n));
          stp++;
        end
        case (cmd)
          CMD_LOOKUP: begin
            if (found) begin
              r.status = ST_OK;
              r.stored_value = value_mem[hit_at];
              r.slot_index = hit_at[9:0];
            end
          end
          CMD_INSERT: begin
            if (found) begin
              value_mem[hit_at] = val;
              r.status = ST_OK;
              r.slot_index = hit_at[9:0];
            end else if (have_gone || have_free) begin
              t = have_gone ? gone_at : free_at;
              hash_mem[t] = h;
              key_mem[t] = k;
              value_mem[t] = val;
              if (occupied != CountMax) occupied++;
              r.status = ST_OK;
              r.slot_index = t[9:0];
            end else begin
              r.status = ST_FULL;
            end
          end
          default: begin
            if (found) begin
              hash_mem[hit_at] = HashGone;
              if (occupied != 0) occupied--;
              r.status = ST_OK;
              r.slot_index = hit_at[9:0];
            end
          end
        endcase
      end
      r.occupied_count = occupied;
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [55:0] data);
      table_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: result with none pending: status %0d data %h", $time, st, data);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      case (exp_r.status)
        ST_OK: hits++;
        ST_FULL: fulls++;
        default: misses++;
      endcase
      if (st != exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, st);
        errors++;
      end
      if (data[31:0] != exp_r.stored_value) begin
        $display("%0t: stored_value expected %h actual %h", $time,
                 exp_r.stored_value, data[31:0]);
        errors++;
      end
      if (data[41:32] != exp_r.slot_index) begin
        $display("%0t: slot_index expected %0d actual %0d", $time,
                 exp_r.slot_index, data[41:32]);
        errors++;
      end
      if (data[52:42] != exp_r.occupied_count) begin
        $display("%0t: occupied_count expected %0d actual %0d", $time,
                 exp_r.occupied_count, data[52:42]);
        errors++;
      end
      if (data[55:53] != 3'b0) begin
        $display("%0t: pad bits expected 0 actual %b", $time, data[55:53]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  table_scoreboard sb = new();
  logic [63:0] key_pool[$];
  int unsigned idle_cycles = 0;
  int unsigned rx_hold = 0;
  bit          rx_stall_on = 1'b1;

  always #5 clk_i = ~clk_i;

  quadratic_probe_hash_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Check results at the rising edge; hold ready across random stalls.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  always @(negedge clk_i) begin
    int unsigned g;
    if (!rx_stall_on) begin
      rx_hold <= 0;
      m_axis_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      g = gap_len();
      rx_hold <= (g == 0) ? 0 : g - 1;
      m_axis_tready <= (g == 0);
    end
  end

  // Watchdog: count cycles with no transfer on either side. The clearing
  // sweep of all NumSlots slots after reset ends well under the limit.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: %0d idle cycles, %0d results pending", idle_cycles,
                 sb.pending.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Present one command and hold it until the transfer completes.
  task automatic send_command(logic [1:0] cmd, logic [63:0] k, logic [31:0] val);
    repeat (1 + gap_len()) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {val, k};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, k, val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= {$urandom(), $urandom(), $urandom()};
  endtask

  // Drain results, let the block settle, then write the modulus.
  task automatic write_slots(logic [10:0] n);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    sb.slots_cfg = n;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly reuse known keys so lookups and removes hit.
  function automatic logic [63:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 99) < 70)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return rand_key();
  endfunction

  task automatic random_phase(int unsigned count, int unsigned pool_max);
    logic [63:0] k;
    int unsigned pick;
    logic [1:0] cmd;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_INSERT;
      else if (pick < 75) cmd = CMD_LOOKUP;
      else if (pick < 97) cmd = CMD_REMOVE;
      else cmd = CmdUnused;
      k = pick_key();
      if (cmd == CMD_INSERT && key_pool.size() < pool_max) key_pool.push_back(k);
      send_command(cmd, k, $urandom());
    end
  endtask

  initial begin
    logic [63:0] k;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of key and value, every command, unused code.
    send_command(CMD_LOOKUP, 64'h0, 32'h0);
    send_command(CMD_INSERT, 64'h0, 32'hffff_ffff);
    send_command(CMD_INSERT, 64'hffff_ffff_ffff_ffff, 32'h0);
    send_command(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h1234_5678);
    send_command(CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h8000_0001);
    send_command(CMD_LOOKUP, 64'h0, 32'h0);
    send_command(CMD_LOOKUP, 64'h8000_0000_0000_0000, 32'hffff_ffff);
    send_command(CMD_INSERT, 64'h0, 32'h5a5a_a5a5);   // overwrite in place
    send_command(CMD_LOOKUP, 64'h0, 32'h0);
    send_command(CMD_REMOVE, 64'hffff_ffff_ffff_ffff, 32'h0);
    send_command(CMD_REMOVE, 64'hffff_ffff_ffff_ffff, 32'h0);  // miss
    send_command(CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'h0);
    send_command(CmdUnused, 64'h7fff_ffff_ffff_ffff, 32'hffff_ffff);
    send_command(CMD_INSERT, 64'h1, 32'h1);             // may reuse deleted slot

    // Tiny table: fill it, hit full, remove, reuse deleted slots.
    write_slots(11'd3);
    for (int unsigned i = 0; i < 8; i++) begin
      k = rand_key();
      key_pool.push_back(k);
      send_command(CMD_INSERT, k, $urandom());
    end
    random_phase(60, 12);

    // Modulus out of range both ways; one slot, then above the slot count.
    write_slots(11'd0);
    random_phase(30, 14);
    write_slots(11'd1);
    random_phase(30, 16);
    write_slots(11'h7ff);
    key_pool.delete();
    random_phase(200, 300);

    // Small primes with a small key pool keep probe walks busy; then the full slot count and the reset value.
    write_slots(11'd7);
    key_pool.delete();
    random_phase(120, 10);
    write_slots(11'd31);
    rx_stall_on = 1'b0;
    random_phase(80, 40);
    rx_stall_on = 1'b1;
    write_slots(11'd1024);
    random_phase(150, 200);
    write_slots(SlotsRst);
    random_phase(200, 250);

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("covered %0d commands over several table sizes: %0d done, %0d misses, %0d full",
             sb.checked, sb.hits, sb.misses, sb.fulls);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/qpht_pkg.sv
rtl/core/qpht_mix.sv
rtl/core/qpht_mod.sv
rtl/core/qpht_store.sv
rtl/core/quadratic_probe_hash_table.sv
tb/sv/testbench.sv
